// ===== rtl/llp_pkg.sv =====
// Shared types and constants of the lidar packet parser.
// No dependencies; imported by llp_framer, llp_emitter and lidar_packet_parser.
package llp_pkg;

    localparam int PKT_LEN   = 36;
    localparam int HDR_LEN   = 4;
    localparam int BODY_LEN  = PKT_LEN - HDR_LEN - 2;   // bytes 4..33, CRC not kept
    localparam int N_SAMPLES = 8;

    localparam logic [7:0] SYNC_0 = 8'h55;
    localparam logic [7:0] SYNC_1 = 8'hAA;
    localparam logic [7:0] SYNC_2 = 8'h03;
    localparam logic [7:0] SYNC_3 = 8'h08;

    localparam logic [15:0] ANGLE_BIAS = 16'd40960;
    // Lowest code that truncates to zero degrees, highest code below 360 degrees
    localparam logic [15:0] ANGLE_CODE_MIN = 16'd40897;
    localparam logic [15:0] ANGLE_CODE_MAX = 16'd63999;
    localparam logic [9:0]  DEG_LIMIT      = 10'd360;

    // x / 7 == (x * RECIP_7) >> RECIP_SHIFT for x up to 7 * 359
    localparam logic [12:0] RECIP_7     = 13'd4682;
    localparam int          RECIP_SHIFT = 15;

    typedef struct packed {
        logic                        valid;
        logic [8:0]                  begin_deg;
        logic [8:0]                  span_deg;
        logic [9:0]                  speed_rpm;
        logic [N_SAMPLES-1:0][15:0]  dist_words;
    } t_decode;

endpackage

// ===== rtl/lidar_packet_parser.sv =====
// Top level of the lidar scan packet parser: byte framer plus sample emitter.
// Depends on llp_pkg, llp_framer and llp_emitter.
// After a packet's final byte is taken, the emitter latches it and feeds the output register.
// Throughput: one byte per cycle unless o_stall; eight samples one per cycle unless i_stall.
// The final byte of a packet is held off while the previous packet's samples still drain.
// Reset (synchronous, active low) returns to header hunt and empties the output register.
module lidar_packet_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [8:0]  o_angle_deg,
    output logic [15:0] o_distance,
    output logic [9:0]  o_speed_rpm,
    output logic        o_last_sample
);
    import llp_pkg::*;

    t_decode decode;
    logic    busy;

    // Hunt for 55 AA 03 08, capture the body and decode the angle codes on the last byte.
    // A decode that fails the range check produces no valid pulse, so the packet is dropped.
    llp_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_busy    (busy),
        .o_stall   (o_stall),
        .o_decode  (decode)
    );

    // Latch a decoded packet and walk its eight samples, one per free output slot.
    llp_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_decode      (decode),
        .i_stall       (i_stall),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_angle_deg   (o_angle_deg),
        .o_distance    (o_distance),
        .o_speed_rpm   (o_speed_rpm),
        .o_last_sample (o_last_sample)
    );

endmodule

// ===== rtl/llp_framer.sv =====
// Header hunt, packet byte capture and angle decode of the lidar packet parser.
// Depends on llp_pkg.
module llp_framer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_busy,
    output logic            o_stall,
    output llp_pkg::t_decode o_decode
);
    import llp_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [5:0] r_count, n_count;
    logic [7:0] r_body [BODY_LEN];

    logic       accept;
    logic       final_byte;
    logic       store;
    logic [4:0] w_idx;
    logic [7:0] sync_exp;

    logic [15:0] begin_code, end_code, begin_off, end_off;
    logic [15:0] speed_word;
    logic [8:0]  begin_deg, end_deg;
    logic        angles_ok;
    logic [9:0]  span_wide;

    assign final_byte = (r_phase == PH_PAY) && (r_count == 6'(PKT_LEN - 1));
    // Hold the last byte of a packet while the previous packet still drains
    assign o_stall    = i_busy && final_byte;
    assign accept     = i_valid && !o_stall;

    always_comb begin
        unique case (r_count[1:0])
            2'd1:    sync_exp = SYNC_1;
            2'd2:    sync_exp = SYNC_2;
            2'd3:    sync_exp = SYNC_3;
            default: sync_exp = SYNC_0;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        store   = 1'b0;
        unique case (r_phase)
            PH_HDR: begin
                if (r_count >= 6'd1 && r_count < 6'(HDR_LEN) && i_rx_byte == sync_exp) begin
                    n_count = r_count + 6'd1;
                    if (n_count == 6'(HDR_LEN)) n_phase = PH_PAY;
                end else begin
                    n_count = '0;
                    n_phase = PH_HUNT;
                end
            end
            PH_PAY: begin
                if (r_count >= 6'(HDR_LEN) && r_count < 6'(PKT_LEN)) begin
                    store   = r_count < 6'(HDR_LEN + BODY_LEN);
                    n_count = r_count + 6'd1;
                    if (n_count == 6'(PKT_LEN)) begin
                        n_count = '0;
                        n_phase = PH_HUNT;
                    end
                end else begin
                    n_count = '0;
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                if (i_rx_byte == SYNC_0) begin
                    n_count = 6'd1;
                    n_phase = PH_HDR;
                end else begin
                    n_count = '0;
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign w_idx = 5'(r_count - 6'(HDR_LEN));

    always_ff @(posedge i_clk) begin
        if (accept && store) r_body[w_idx] <= i_rx_byte;
    end

    // Angle codes: begin at bytes 6..7, end at bytes 32..33
    assign begin_code = {r_body[3], r_body[2]};
    assign end_code   = {r_body[29], r_body[28]};
    assign speed_word = {r_body[1], r_body[0]};
    assign begin_off  = begin_code - ANGLE_BIAS;
    assign end_off    = end_code - ANGLE_BIAS;
    assign begin_deg  = (begin_code >= ANGLE_BIAS) ? begin_off[14:6] : 9'd0;
    assign end_deg    = (end_code >= ANGLE_BIAS) ? end_off[14:6] : 9'd0;
    assign angles_ok  = begin_code >= ANGLE_CODE_MIN && begin_code <= ANGLE_CODE_MAX &&
                        end_code >= ANGLE_CODE_MIN && end_code <= ANGLE_CODE_MAX;
    assign span_wide  = (end_deg >= begin_deg) ? ({1'b0, end_deg} - {1'b0, begin_deg})
                      : ({1'b0, end_deg} + DEG_LIMIT - {1'b0, begin_deg});

    always_comb begin
        o_decode.valid     = accept && final_byte && angles_ok;
        o_decode.begin_deg = begin_deg;
        o_decode.span_deg  = span_wide[8:0];
        o_decode.speed_rpm = speed_word[15:6];
        for (int k = 0; k < N_SAMPLES; k++) begin
            o_decode.dist_words[k] = {r_body[4 + 3 * k + 1], r_body[4 + 3 * k]};
        end
    end

endmodule

// ===== rtl/llp_emitter.sv =====
// Angle interpolation and result register of the lidar packet parser.
// Depends on llp_pkg.
module llp_emitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  llp_pkg::t_decode i_decode,
    input  logic             i_stall,
    output logic             o_busy,
    output logic             o_valid,
    output logic [8:0]       o_angle_deg,
    output logic [15:0]      o_distance,
    output logic [9:0]       o_speed_rpm,
    output logic             o_last_sample
);
    import llp_pkg::*;

    logic                       r_busy;
    logic [2:0]                 r_k;
    logic [11:0]                r_acc;
    logic [8:0]                 r_begin;
    logic [8:0]                 r_span;
    logic [9:0]                 r_speed;
    logic [N_SAMPLES-1:0][15:0] r_dist;

    logic                       r_ov;
    logic [8:0]                 r_angle;
    logic [15:0]                r_distance;
    logic [9:0]                 r_rpm;
    logic                       r_last;

    logic        out_free, emit;
    logic [24:0] prod;
    logic [8:0]  step;
    logic [9:0]  sum;
    logic [8:0]  angle;

    assign out_free = !r_ov || !i_stall;
    assign emit     = r_busy && out_free;

    // begin + span*k/7, wrapped at 360
    assign prod  = 25'(r_acc) * 25'(RECIP_7);
    assign step  = prod[RECIP_SHIFT +: 9];
    assign sum   = {1'b0, r_begin} + {1'b0, step};
    assign angle = (sum >= DEG_LIMIT) ? 9'(sum - DEG_LIMIT) : sum[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_decode.valid) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (emit) begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'(N_SAMPLES - 1)) r_busy <= 1'b0;
            end
            if (emit)          r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_decode.valid) begin
            r_acc   <= '0;
            r_begin <= i_decode.begin_deg;
            r_span  <= i_decode.span_deg;
            r_speed <= i_decode.speed_rpm;
            r_dist  <= i_decode.dist_words;
        end else if (emit) begin
            r_acc <= r_acc + 12'(r_span);
        end
        if (emit) begin
            r_angle    <= angle;
            r_distance <= r_dist[r_k];
            r_rpm      <= r_speed;
            r_last     <= (r_k == 3'(N_SAMPLES - 1));
        end
    end

    assign o_busy        = r_busy;
    assign o_valid       = r_ov;
    assign o_angle_deg   = r_angle;
    assign o_distance    = r_distance;
    assign o_speed_rpm   = r_rpm;
    assign o_last_sample = r_last;

endmodule
